>>> rtl/gbh_pkg.sv
// ----------------------------------------------------------------------------
// gbh_pkg
// Shared types and constants for the grid binning block with halo output.
// ----------------------------------------------------------------------------
`default_nettype none

package gbh_pkg;

   localparam int PART_BITS_DEF = 8;
   localparam int DIV_W         = 35;   // width of c - origin + margin, signed
   localparam int DEST_W        = 24;
   localparam int NUM_DEST      = 8;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_ORIGIN_Z   = 3'd2,
      CSR_CELL_LEN_X = 3'd3,
      CSR_CELL_LEN_Y = 3'd4,
      CSR_CELL_LEN_Z = 3'd5,
      CSR_MARGIN     = 3'd6,
      CSR_GRID_DIMS  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        vertex_handle;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [DEST_W-1:0]  dest_part;
      logic [31:0]        out_handle;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/grid_bin_with_halo_dest.sv
// The first result of a vertex passes the front stage, the divider stages, the clamp
// stage, the index stages and the emitter register on its way to the ports.
// The result emitter sends one destination per cycle and holds the pipeline until
// it sends the last destination of a vertex. busy is high while a vertex waits
// in the last stage and the emitter is still sending an earlier vertex.
// Reset (synchronous): pipeline and emitter empty, registers at defaults.
// ----------------------------------------------------------------------------
// grid_bin_with_halo_dest
// Bins a vertex into a 3-D uniform grid and sends its base and halo cells.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_bin_with_halo_dest #(
   parameter int PART_BITS = gbh_pkg::PART_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire gbh_pkg::req_type req_data,
   output logic                  rsp_valid,
   output gbh_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_data
);

   localparam int DW    = gbh_pkg::DIV_W;
   localparam int IDX_W = 3 * PART_BITS + 2;
   localparam int N     = PART_BITS + 5;

   // Configuration registers.
   logic signed [31:0] org_ff [0:2];
   logic [30:0]        len_ff [0:2];
   logic [30:0]        margin_ff;
   logic [23:0]        dims_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            org_ff[a] <= '0;
            len_ff[a] <= 31'd65536;
         end
         margin_ff <= '0;
         dims_ff   <= 24'd65793;
      end else if (csr_valid && csr_ready) begin
         unique case (gbh_pkg::csr_index_type'(csr_index))
            gbh_pkg::CSR_ORIGIN_X:   org_ff[0] <= csr_data;
            gbh_pkg::CSR_ORIGIN_Y:   org_ff[1] <= csr_data;
            gbh_pkg::CSR_ORIGIN_Z:   org_ff[2] <= csr_data;
            gbh_pkg::CSR_CELL_LEN_X: len_ff[0] <= csr_data[30:0];
            gbh_pkg::CSR_CELL_LEN_Y: len_ff[1] <= csr_data[30:0];
            gbh_pkg::CSR_CELL_LEN_Z: len_ff[2] <= csr_data[30:0];
            gbh_pkg::CSR_MARGIN:     margin_ff <= csr_data[30:0];
            gbh_pkg::CSR_GRID_DIMS:  dims_ff   <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // Derived constants; configuration only moves while the block is idle.
   logic [3*PART_BITS-1:0] dims_ext;
   logic [PART_BITS-1:0]   cnt   [0:2];
   logic [30:0]            den   [0:2];
   logic [2*PART_BITS-1:0] pxy_ff;
   logic [IDX_W-1:0]       off_ff [0:7];
   logic [IDX_W-1:0]       sx, sy, sz;

   always_comb begin
      dims_ext = (3 * PART_BITS)'(dims_ff);
      for (int a = 0; a < 3; a++) begin
         cnt[a] = dims_ext[a*PART_BITS +: PART_BITS];
         if (cnt[a] == '0) begin
            cnt[a] = PART_BITS'(1);
         end
         den[a] = (len_ff[a] == '0) ? 31'd1 : len_ff[a];
      end
      sx = IDX_W'(1);
      sy = IDX_W'(cnt[0]);
      sz = IDX_W'(pxy_ff);
   end

   always_ff @(posedge clock) begin
      pxy_ff    <= (2 * PART_BITS)'(cnt[0]) * (2 * PART_BITS)'(cnt[1]);
      off_ff[0] <= '0;
      off_ff[1] <= sx;
      off_ff[2] <= sy;
      off_ff[3] <= sz;
      off_ff[4] <= sx + sy;
      off_ff[5] <= sx + sz;
      off_ff[6] <= sy + sz;
      off_ff[7] <= sx + sy + sz;
   end

   // Pipeline control: one global advance, valid bits ride with the data.
   logic adv;
   logic can_load;
   logic vld_ff [0:N-1];
   gbh_pkg::req_type pay_ff [0:N-1];
   logic idle;

   assign adv  = !vld_ff[N-1] || can_load;
   assign busy = !adv;

   // A register write is taken only when no transaction is in flight or arriving.
   always_comb begin
      idle = !rsp_valid;
      for (int s = 0; s < N; s++) begin
         if (vld_ff[s]) begin
            idle = 1'b0;
         end
      end
   end

   assign csr_ready = idle && !start;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < N; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= start;
         for (int s = 1; s < N; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pay_ff[0] <= req_data;
         for (int s = 1; s < N; s++) begin
            pay_ff[s] <= pay_ff[s-1];
         end
      end
   end

   // Front stage: offsets from the origin, plain and shifted by the margin.
   logic signed [31:0] coord [0:2];
   logic [DW-1:0]      d_ff  [0:2];
   logic [DW-1:0]      dm_ff [0:2];

   assign coord[0] = req_data.coord_x;
   assign coord[1] = req_data.coord_y;
   assign coord[2] = req_data.coord_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            d_ff[a]  <= DW'(coord[a]) - DW'(org_ff[a]);
            dm_ff[a] <= DW'(coord[a]) - DW'(org_ff[a]) + DW'(margin_ff);
         end
      end
   end

   // Dividers, one pair per axis.
   logic [PART_BITS-1:0] q   [0:2];
   logic [PART_BITS-1:0] qm  [0:2];
   logic                 qn  [0:2];
   logic                 qmn [0:2];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      gbh_divider #(.PART_BITS(PART_BITS)) u_div_base (
         .clock (clock),
         .en    (adv),
         .num   (d_ff[a]),
         .den   (den[a]),
         .quot  (q[a]),
         .neg   (qn[a])
      );
      gbh_divider #(.PART_BITS(PART_BITS)) u_div_halo (
         .clock (clock),
         .en    (adv),
         .num   (dm_ff[a]),
         .den   (den[a]),
         .quot  (qm[a]),
         .neg   (qmn[a])
      );
   end

   // Clamp and halo flags.
   logic [PART_BITS-1:0] idx_in  [0:2];
   logic                 halo_in [0:2];
   logic [PART_BITS-1:0] idx_ff  [0:2];
   logic [2:0]           halo_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (qn[a]) begin
            idx_in[a] = '0;
         end else if (q[a] > cnt[a] - PART_BITS'(1)) begin
            idx_in[a] = cnt[a] - PART_BITS'(1);
         end else begin
            idx_in[a] = q[a];
         end
         halo_in[a] = !qmn[a] && (qm[a] > idx_in[a]) && (qm[a] < cnt[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            idx_ff[a]  <= idx_in[a];
            halo_ff[a] <= halo_in[a];
         end
      end
   end

   // Linear part index over two stages.
   logic [PART_BITS-1:0]   ix_m1_ff;
   logic [2*PART_BITS-1:0] t_ff;
   logic [3*PART_BITS-1:0] u_ff;
   logic [2:0]             halo_m1_ff;
   logic [IDX_W-1:0]       base_ff;
   logic [2:0]             halo_m2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ix_m1_ff   <= idx_ff[0];
         t_ff       <= (2 * PART_BITS)'(idx_ff[1]) * (2 * PART_BITS)'(cnt[0]);
         u_ff       <= (3 * PART_BITS)'(idx_ff[2]) * (3 * PART_BITS)'(pxy_ff);
         halo_m1_ff <= halo_ff;
         base_ff    <= IDX_W'(ix_m1_ff) + IDX_W'(t_ff) + IDX_W'(u_ff);
         halo_m2_ff <= halo_m1_ff;
      end
   end

   logic [7:0] mask;

   assign mask = {&halo_m2_ff,
                  halo_m2_ff[1] & halo_m2_ff[2],
                  halo_m2_ff[0] & halo_m2_ff[2],
                  halo_m2_ff[0] & halo_m2_ff[1],
                  halo_m2_ff[2], halo_m2_ff[1], halo_m2_ff[0], 1'b1};

   gbh_emit #(.PART_BITS(PART_BITS)) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (adv && vld_ff[N-1]),
      .in_mask   (mask),
      .in_base   (base_ff),
      .in_pay    (pay_ff[N-1]),
      .off       (off_ff),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/gbh_divider.sv
// ----------------------------------------------------------------------------
// gbh_divider
// Pipelined restoring floor divider, one quotient bit per stage, quotient
// saturated to PART_BITS bits; a negative dividend is flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module gbh_divider #(
   parameter int PART_BITS = gbh_pkg::PART_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [gbh_pkg::DIV_W-1:0]  num,
   input  wire logic [30:0]                den,
   output logic      [PART_BITS-1:0]       quot,
   output logic                            neg
);

   localparam int DW = gbh_pkg::DIV_W;
   localparam int CW = (31 + PART_BITS > DW) ? 31 + PART_BITS : DW;

   logic [DW-1:0]        rem_ff [0:PART_BITS];
   logic [DW-1:0]        rem_in [0:PART_BITS];
   logic [PART_BITS-1:0] quo_ff [0:PART_BITS];
   logic [PART_BITS-1:0] quo_in [0:PART_BITS];
   logic                 neg_ff [0:PART_BITS];
   logic                 neg_in [0:PART_BITS];
   logic                 sat_ff [0:PART_BITS];
   logic                 sat_in [0:PART_BITS];
   logic [CW-1:0]        trial  [0:PART_BITS];
   logic                 ge     [0:PART_BITS];

   always_comb begin
      // The first stage catches quotients that do not fit in PART_BITS bits.
      trial[0]  = CW'({den, {PART_BITS{1'b0}}});
      ge[0]     = CW'(num) >= trial[0];
      rem_in[0] = num;
      neg_in[0] = num[DW-1];
      sat_in[0] = !num[DW-1] && ge[0];
      quo_in[0] = '0;
      for (int k = 1; k <= PART_BITS; k++) begin
         trial[k]  = CW'(den) << (PART_BITS - k);
         ge[k]     = CW'(rem_ff[k-1]) >= trial[k];
         rem_in[k] = ge[k] ? rem_ff[k-1] - trial[k][DW-1:0] : rem_ff[k-1];
         quo_in[k] = quo_ff[k-1];
         quo_in[k][PART_BITS-k] = ge[k];
         neg_in[k] = neg_ff[k-1];
         sat_in[k] = sat_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= PART_BITS; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            neg_ff[k] <= neg_in[k];
            sat_ff[k] <= sat_in[k];
         end
      end
   end

   assign quot = sat_ff[PART_BITS] ? {PART_BITS{1'b1}} : quo_ff[PART_BITS];
   assign neg  = neg_ff[PART_BITS];

endmodule

`default_nettype wire

>>> rtl/gbh_emit.sv
// ----------------------------------------------------------------------------
// gbh_emit
// Walks the destination mask of one vertex and sends one result per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbh_emit #(
   parameter int PART_BITS = gbh_pkg::PART_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire logic [7:0]              in_mask,
   input  wire logic [3*PART_BITS+1:0]  in_base,
   input  wire gbh_pkg::req_type        in_pay,
   input  wire logic [3*PART_BITS+1:0]  off [0:7],
   output logic                         can_load,
   output logic                         rsp_valid,
   output gbh_pkg::rsp_type             rsp_data
);

   localparam int IDX_W = 3 * PART_BITS + 2;

   logic [7:0]       mask_ff, mask_in;
   logic [IDX_W-1:0] base_ff;
   gbh_pkg::req_type pay_ff;
   logic [2:0]       sel;
   logic [7:0]       pick;
   logic [IDX_W-1:0] dest;
   logic             last;

   always_comb begin
      sel = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (mask_ff[k]) begin
            sel = 3'(k);
         end
      end
      pick     = 8'd1 << sel;
      last     = (mask_ff & ~pick) == 8'd0;
      dest     = base_ff + off[sel];
      can_load = (mask_ff == 8'd0) || last;
      mask_in  = load ? in_mask : (mask_ff & ~pick);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 8'd0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         base_ff <= in_base;
         pay_ff  <= in_pay;
      end
   end

   assign rsp_valid           = mask_ff != 8'd0;
   assign rsp_data.dest_part  = gbh_pkg::DEST_W'(dest);
   assign rsp_data.out_handle = pay_ff.vertex_handle;
   assign rsp_data.out_x      = pay_ff.coord_x;
   assign rsp_data.out_y      = pay_ff.coord_y;
   assign rsp_data.out_z      = pay_ff.coord_z;
   assign rsp_data.last       = last;

endmodule

`default_nettype wire
